FILE: rtl/lrbd_pkg.sv
// Shared types and codes for the run-length pattern bitmap decoder.
`timescale 1ns / 1ps

package lrbd_pkg;

  // Operation codes carried by the input beat.
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_DECODE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  // Pattern text characters.
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_LIVE = 8'h6F;  // 'o'
  localparam logic [7:0] CH_DEAD = 8'h62;  // 'b'
  localparam logic [7:0] CH_EOL  = 8'h24;  // '$'
  localparam logic [7:0] CH_END  = 8'h21;  // '!'

  // Configuration register indexes.
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  localparam logic [8:0]  SIZE_RESET = 9'd256;
  localparam logic [15:0] SAT16      = 16'hFFFF;
  localparam logic [7:0]  LEFT_CELL  = 8'h80;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic item_load;
    logic parser_clear;
    logic clr_step;
    logic decode;
    logic paint_rd;
    logic paint_wr;
    logic rd_issue;
    logic out_load;
  } lrbd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic paint_go;
    logic paint_last;
  } lrbd_sts_t;

endpackage

FILE: rtl/lrbd_ctrl.sv
// Controller state machine: sequences clearing, decoding, painting and reads.
`timescale 1ns / 1ps

module lrbd_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [1:0]            in_operation,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  output lrbd_pkg::lrbd_cmd_t   cmd,
  input  lrbd_pkg::lrbd_sts_t   sts
);
  import lrbd_pkg::*;

  typedef enum logic [7:0] {
    S_INIT     = 8'b0000_0001,
    S_IDLE     = 8'b0000_0010,
    S_CLEAR    = 8'b0000_0100,
    S_DECODE   = 8'b0000_1000,
    S_PAINT_RD = 8'b0001_0000,
    S_PAINT_WR = 8'b0010_0000,
    S_READ     = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_INIT: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.item_load = 1'b1;
          priority if (in_operation == OP_CLEAR) begin
            cmd.parser_clear = 1'b1;
            state_nxt        = S_CLEAR;
          end else if (in_operation == OP_DECODE) begin
            state_nxt = S_DECODE;
          end else if (in_operation == OP_READ) begin
            state_nxt = S_READ;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        state_nxt  = sts.paint_go ? S_PAINT_RD : S_DONE;
      end
      S_PAINT_RD: begin
        cmd.paint_rd = 1'b1;
        state_nxt    = S_PAINT_WR;
      end
      S_PAINT_WR: begin
        cmd.paint_wr = 1'b1;
        state_nxt    = sts.paint_last ? S_DONE : S_PAINT_RD;
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        // The result waits here while the previous beat is still unclaimed.
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: rtl/lrbd_dp.sv
// Datapath: parser registers, cell store memory, paint and read logic.
`timescale 1ns / 1ps

module lrbd_dp #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lrbd_pkg::lrbd_cmd_t   cmd,
  output lrbd_pkg::lrbd_sts_t   sts,
  input  logic [1:0]            in_operation,
  input  logic [7:0]            in_character,
  input  logic [7:0]            in_read_row,
  input  logic [4:0]            in_read_byte_column,
  input  logic                  cfg_wr_en,
  input  logic                  cfg_index,
  input  logic [8:0]            cfg_data,
  output logic [7:0]            out_read_data,
  output logic                  out_finished,
  output logic [15:0]           out_current_row
);
  import lrbd_pkg::*;

  localparam int ROW_BYTES   = (MAX_WIDTH + 7) / 8;
  localparam int STORE_BYTES = ROW_BYTES * MAX_HEIGHT;
  localparam int AW          = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

  // Item registers.
  logic [1:0] item_op_r;
  logic [7:0] item_char_r;
  logic [7:0] item_row_r;
  logic [4:0] item_bcol_r;

  // Configuration.
  logic [8:0] pattern_width_r, pattern_height_r;

  // Parser state.
  logic [15:0] col_r, col_nxt;
  logic [15:0] row_r, row_nxt;
  logic [15:0] digit_r, digit_nxt;
  logic [15:0] skip_r, skip_nxt;
  logic        digits_seen_r, digits_seen_nxt;
  logic        ended_r, ended_nxt;

  // Clearing pass and run painting.
  logic [AW-1:0] clr_addr_r;
  logic [9:0]    pcol_r;
  logic [8:0]    plast_r;
  logic [AW-1:0] row_base_r;

  // Cell store.
  logic [7:0]    mem [STORE_BYTES];
  logic [7:0]    mem_q_r;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata;

  logic [7:0]  out_read_data_r;
  logic        out_finished_r;
  logic [15:0] out_current_row_r;

  logic [8:0]  eff_w, eff_h;
  logic [15:0] count;
  logic        is_digit;
  logic [19:0] digit_wide;
  logic [15:0] digit_sat;
  logic [16:0] col_sum;
  logic [15:0] col_sat;
  logic [15:0] row_step;
  logic [16:0] row_sum;
  logic [15:0] row_sat;
  logic [8:0]  run_last;
  logic        paint_go;
  logic [8:0]  last_m1;
  logic [2:0]  mask_hi;
  logic [7:0]  paint_mask;
  logic [9:0]  pcol_next;
  logic [AW-1:0] paint_addr;
  logic          rd_ok;
  logic [AW-1:0] rd_addr;

  // Effective bitmap size, bounded by the store geometry.
  assign eff_w = (32'(pattern_width_r) < MAX_WIDTH) ? pattern_width_r : 9'(MAX_WIDTH);
  assign eff_h = (32'(pattern_height_r) < MAX_HEIGHT) ? pattern_height_r : 9'(MAX_HEIGHT);

  assign count    = digits_seen_r ? digit_r : 16'd1;
  assign is_digit = (item_char_r >= CH_ZERO) && (item_char_r <= CH_NINE);

  // Times ten as two shifts and an add.
  always_comb begin
    if (digits_seen_r) begin
      digit_wide = 20'({digit_r, 3'b000}) + 20'({digit_r, 1'b0})
                 + 20'(item_char_r - CH_ZERO);
    end else begin
      digit_wide = 20'(item_char_r - CH_ZERO);
    end
  end
  assign digit_sat = (digit_wide > 20'(SAT16)) ? SAT16 : digit_wide[15:0];

  assign col_sum  = 17'(col_r) + 17'(count);
  assign col_sat  = col_sum[16] ? SAT16 : col_sum[15:0];
  assign row_step = (skip_r != 16'd0) ? skip_r : 16'd1;
  assign row_sum  = 17'(row_r) + 17'(row_step);
  assign row_sat  = row_sum[16] ? SAT16 : row_sum[15:0];

  assign run_last = (col_sum > 17'(eff_w)) ? eff_w : col_sum[8:0];
  assign paint_go = (item_char_r == CH_LIVE) && !ended_r && (row_r < 16'(eff_h))
                  && (col_r < 16'(eff_w)) && (count != 16'd0);

  // Byte mask for the cells of the run that fall in the current byte; the first
  // cell of a byte is its top bit.
  assign last_m1 = plast_r - 9'd1;
  assign mask_hi = (pcol_r[9:3] == {1'b0, last_m1[8:3]}) ? last_m1[2:0] : 3'd7;
  always_comb begin
    paint_mask = 8'd0;
    for (int i = 0; i < 8; i++) begin
      if ((3'(i) >= pcol_r[2:0]) && (3'(i) <= mask_hi)) begin
        paint_mask = paint_mask | (LEFT_CELL >> i);
      end
    end
  end

  assign pcol_next  = {pcol_r[9:3] + 7'd1, 3'b000};
  assign paint_addr = row_base_r + AW'(pcol_r[9:3]);

  assign rd_ok   = (32'(item_row_r) < MAX_HEIGHT) && (32'(item_bcol_r) < ROW_BYTES);
  assign rd_addr = AW'(item_row_r) * AW'(ROW_BYTES) + AW'(item_bcol_r);

  assign sts.clr_last   = (clr_addr_r == AW'(STORE_BYTES - 1));
  assign sts.paint_go   = paint_go;
  assign sts.paint_last = (pcol_next >= {1'b0, plast_r});

  // Parser step for one decoded character.
  always_comb begin
    col_nxt         = col_r;
    row_nxt         = row_r;
    digit_nxt       = digit_r;
    skip_nxt        = skip_r;
    digits_seen_nxt = digits_seen_r;
    ended_nxt       = ended_r;
    if (cmd.parser_clear) begin
      col_nxt         = '0;
      row_nxt         = '0;
      digit_nxt       = '0;
      skip_nxt        = '0;
      digits_seen_nxt = 1'b0;
      ended_nxt       = 1'b0;
    end else if (cmd.decode && !ended_r) begin
      priority if (is_digit) begin
        digit_nxt       = digit_sat;
        digits_seen_nxt = 1'b1;
        skip_nxt        = digit_sat;
      end else if (item_char_r == CH_LIVE || item_char_r == CH_DEAD) begin
        digit_nxt       = '0;
        digits_seen_nxt = 1'b0;
        col_nxt         = col_sat;
        skip_nxt        = '0;
      end else if (item_char_r == CH_EOL) begin
        digit_nxt       = '0;
        digits_seen_nxt = 1'b0;
        row_nxt         = row_sat;
        col_nxt         = '0;
        skip_nxt        = '0;
      end else if (item_char_r == CH_END) begin
        digit_nxt       = '0;
        digits_seen_nxt = 1'b0;
        ended_nxt       = 1'b1;
      end else begin
        // Any other character keeps its count as the row skip.
        digit_nxt       = '0;
        digits_seen_nxt = 1'b0;
        skip_nxt        = count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_width_r  <= SIZE_RESET;
      pattern_height_r <= SIZE_RESET;
      col_r            <= '0;
      row_r            <= '0;
      digit_r          <= '0;
      skip_r           <= '0;
      digits_seen_r    <= 1'b0;
      ended_r          <= 1'b0;
      clr_addr_r       <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_WIDTH:  pattern_width_r  <= cfg_data;
          CFG_HEIGHT: pattern_height_r <= cfg_data;
          default:    pattern_width_r  <= pattern_width_r;
        endcase
      end
      col_r         <= col_nxt;
      row_r         <= row_nxt;
      digit_r       <= digit_nxt;
      skip_r        <= skip_nxt;
      digits_seen_r <= digits_seen_nxt;
      ended_r       <= ended_nxt;
      if (cmd.parser_clear) begin
        clr_addr_r <= '0;
      end else if (cmd.clr_step) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      item_op_r   <= in_operation;
      item_char_r <= in_character;
      item_row_r  <= in_read_row;
      item_bcol_r <= in_read_byte_column;
    end
    if (cmd.decode && paint_go) begin
      pcol_r     <= {1'b0, col_r[8:0]};
      plast_r    <= run_last;
      row_base_r <= AW'(row_r[8:0]) * AW'(ROW_BYTES);
    end else if (cmd.paint_wr) begin
      pcol_r <= pcol_next;
    end
    if (cmd.out_load) begin
      out_read_data_r   <= (item_op_r == OP_READ && rd_ok) ? mem_q_r : 8'd0;
      out_finished_r    <= ended_r;
      out_current_row_r <= row_r;
    end
  end

  // Single port of the cell store.
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = clr_addr_r;
    mem_wdata = 8'd0;
    priority if (cmd.clr_step) begin
      mem_we = 1'b1;
    end else if (cmd.paint_wr) begin
      mem_we    = 1'b1;
      mem_addr  = paint_addr;
      mem_wdata = mem_q_r | paint_mask;
    end else if (cmd.paint_rd) begin
      mem_re   = 1'b1;
      mem_addr = paint_addr;
    end else if (cmd.rd_issue && rd_ok) begin
      mem_re   = 1'b1;
      mem_addr = rd_addr;
    end else begin
      mem_re = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q_r <= mem[mem_addr];
    end
  end

  assign out_read_data   = out_read_data_r;
  assign out_finished    = out_finished_r;
  assign out_current_row = out_current_row_r;

endmodule

FILE: rtl/life_rle_bitmap_decoder.sv
// Top level of the run-length pattern decoder into a 1-bit-per-cell bitmap.
//
//   Channel | Dir | Beat ports                                      | Flow
//   --------+-----+-------------------------------------------------+-------------------
//   in      | in  | in_operation in_character in_read_row           | in_valid/in_stall
//           |     | in_read_byte_column                             |
//   out     | out | out_read_data out_finished out_current_row      | out_valid/out_stall
//   cfg     | in  | cfg_index cfg_data                              | cfg_wr_en
//
// A decoded character passes through the DECODE state before the result register loads,
// and an unused operation goes straight to it; an 'o' run adds a read then a write of the
// single store port for each store byte it touches. A read issues one store read in READ,
// and a clear writes all ROW_BYTES*MAX_HEIGHT store bytes. The next input beat is taken
// the cycle after the result register loads. After reset a clearing pass writes every
// store byte, one per cycle (8192 bytes at the default size), before the first input beat
// is taken. The result register lets the next beat in while a result still waits; a
// finished item holds in its last step until the previous beat has been taken.
`timescale 1ns / 1ps

module life_rle_bitmap_decoder #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_character,
  input  logic [7:0]  in_read_row,
  input  logic [4:0]  in_read_byte_column,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_read_data,
  output logic        out_finished,
  output logic [15:0] out_current_row,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_data
);
  import lrbd_pkg::*;

  lrbd_cmd_t cmd;
  lrbd_sts_t sts;

  lrbd_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cmd          (cmd),
    .sts          (sts)
  );

  lrbd_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_operation        (in_operation),
    .in_character        (in_character),
    .in_read_row         (in_read_row),
    .in_read_byte_column (in_read_byte_column),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .out_read_data       (out_read_data),
    .out_finished        (out_finished),
    .out_current_row     (out_current_row)
  );

endmodule

FILE: rtl/lrbd_chk.sv
// Port-level checker for the pattern decoder, bound to the top level.
`timescale 1ns / 1ps

module lrbd_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_read_data,
  input logic        out_finished,
  input logic [15:0] out_current_row
);

  logic       in_acc, out_acc;
  logic [1:0] owed_r;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // Items taken whose result beat has not yet gone out.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owed_r <= 2'd0;
    end else begin
      owed_r <= owed_r + 2'(in_acc) - 2'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_data)
      && $stable(out_finished) && $stable(out_current_row))
    else $error("result beat changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("input taken on consecutive cycles");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> owed_r != 2'd0)
    else $error("result beat without an accepted item");

  a_owed_bound: assert property (@(posedge clk) disable iff (!rst_n)
    owed_r != 2'd3)
    else $error("more than two items outstanding");

endmodule

bind life_rle_bitmap_decoder lrbd_chk u_lrbd_chk (.*);
